>>> rtl/cbm_pkg.sv
// Shared types, character constants and lookup functions of the bracket-matching tokenizer.
package cbm_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned MaxWordLenDefault = 255;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RCURLY = 8'h7D;

  typedef enum logic [2:0] {
    MODE_NORMAL, MODE_WORD, MODE_OPER, MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR, MODE_DISCARD
  } mode_e;

  typedef enum logic [2:0] {
    TOK_WORD, TOK_OPER, TOK_COMMA, TOK_SEMI, TOK_OPEN, TOK_CLOSE, TOK_END, TOK_ERROR
  } tok_e;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_ASSIGN, OP_NOT, OP_LT,
    OP_GT, OP_AND, OP_OR, OP_EQ, OP_NE, OP_LE, OP_GE
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_BAD_CHAR, ERR_LONE_AMP_BAR, ERR_MISMATCH, ERR_UNCLOSED_BLOCK,
    ERR_UNCLOSED_COMMENT, ERR_OVERFLOW
  } err_e;

  typedef enum logic [1:0] {BRK_ROUND, BRK_CURLY, BRK_SQUARE} brk_e;

  typedef enum logic [3:0] {
    CL_BAD, CL_WORD, CL_OP, CL_COMMA, CL_SEMI, CL_SPACE, CL_OPEN, CL_CLOSE, CL_END
  } class_e;

  typedef struct packed {
    tok_e        kind;
    op_e         op;
    brk_e        brk;
    logic [6:0]  depth;
    logic [7:0]  len;
    err_e        err;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } scan_out_t;

  localparam result_t RES_IDLE = '0;

  function automatic class_e char_class(input logic [7:0] b);
    class_e c;
    c = CL_BAD;
    if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
        (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDER) begin
      c = CL_WORD;
    end else begin
      case (b)
        CH_NUL:                                   c = CL_END;
        CH_TAB, CH_LF, CH_CR, CH_SPACE:           c = CL_SPACE;
        CH_BANG, CH_PCT, CH_AMP, CH_STAR, CH_PLUS,
        CH_MINUS, CH_SLASH, CH_LT, CH_EQ, CH_GT,
        CH_BAR:                                   c = CL_OP;
        CH_COMMA:                                 c = CL_COMMA;
        CH_SEMI:                                  c = CL_SEMI;
        CH_LPAREN, CH_LSQ, CH_LCURLY:             c = CL_OPEN;
        CH_RPAREN, CH_RSQ, CH_RCURLY:             c = CL_CLOSE;
        default:                                  c = CL_BAD;
      endcase
    end
    return c;
  endfunction

  function automatic op_e op_of(input logic [7:0] b);
    op_e o;
    case (b)
      CH_PLUS:  o = OP_ADD;
      CH_MINUS: o = OP_SUB;
      CH_STAR:  o = OP_MUL;
      CH_SLASH: o = OP_DIV;
      CH_PCT:   o = OP_MOD;
      CH_EQ:    o = OP_ASSIGN;
      CH_BANG:  o = OP_NOT;
      CH_LT:    o = OP_LT;
      CH_GT:    o = OP_GT;
      CH_AMP:   o = OP_AND;
      default:  o = OP_OR;
    endcase
    return o;
  endfunction

  function automatic brk_e brk_of(input logic [7:0] b);
    brk_e k;
    if (b == CH_LPAREN || b == CH_RPAREN) begin
      k = BRK_ROUND;
    end else if (b == CH_LCURLY || b == CH_RCURLY) begin
      k = BRK_CURLY;
    end else begin
      k = BRK_SQUARE;
    end
    return k;
  endfunction

  function automatic result_t mk_result(input tok_e kind, input op_e op, input brk_e brk,
                                        input logic [6:0] depth, input logic [7:0] len,
                                        input err_e err);
    result_t r;
    r.kind  = kind;
    r.op    = op;
    r.brk   = brk;
    r.depth = depth;
    r.len   = len;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/cbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbm_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cbm_scan.sv
// Scanner state, bracket stack and per-byte token decision.
module cbm_scan import cbm_pkg::*; #(
  parameter int unsigned STACK_DEPTH  = StackDepthDefault,
  parameter int unsigned MAX_WORD_LEN = MaxWordLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [7:0]  source_byte_i,
  output scan_out_t   res_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned WCW = $clog2(MAX_WORD_LEN + 1);

  mode_e          mode_q, mode_d;
  op_e            pend_q, pend_d;
  logic [WCW-1:0] wc_q, wc_d;
  logic [SPW-1:0] sp_q, sp_d;
  brk_e           tos_q, tos_d;
  logic           byp_q;
  brk_e           byp_data_q;

  logic [1:0]     ram_rdata;
  brk_e           below;
  logic [SPW-1:0] sp_rd, sp_wr, sp_adr;

  class_e         cls;
  brk_e           k;
  logic [7:0]     b;
  logic [7:0]     wlen;
  op_e            two;
  logic           two_v;
  logic           push, pop, clear, do_plain;
  logic           pre_v, pl_v;
  result_t        pre, pl;

  assign below = byp_q ? byp_data_q : brk_e'(ram_rdata);

  always_comb begin
    b    = source_byte_i;
    cls  = char_class(b);
    k    = brk_of(b);
    wlen = (32'(wc_q) > 32'd255) ? 8'd255 : 8'(wc_q);

    mode_d   = mode_q;
    pend_d   = pend_q;
    wc_d     = wc_q;
    sp_d     = sp_q;
    tos_d    = tos_q;
    push     = 1'b0;
    pop      = 1'b0;
    clear    = 1'b0;
    do_plain = 1'b0;
    pre_v    = 1'b0;
    pre      = RES_IDLE;
    pl_v     = 1'b0;
    pl       = RES_IDLE;
    two      = OP_ADD;
    two_v    = 1'b0;

    case (mode_q)
      MODE_WORD: begin
        if (cls == CL_WORD) begin
          if (32'(wc_q) < 32'(MAX_WORD_LEN)) begin
            wc_d = wc_q + 1'b1;
          end
        end else begin
          pre_v    = 1'b1;
          pre      = mk_result(TOK_WORD, OP_ADD, BRK_ROUND, 7'(sp_q), wlen, ERR_NONE);
          wc_d     = '0;
          do_plain = 1'b1;
        end
      end
      MODE_OPER: begin
        pend_d = OP_ADD;
        if (pend_q == OP_AND && b == CH_AMP) begin
          two_v = 1'b1;
          two   = OP_AND;
        end else if (pend_q == OP_OR && b == CH_BAR) begin
          two_v = 1'b1;
          two   = OP_OR;
        end else if (b == CH_EQ && pend_q >= OP_ASSIGN && pend_q <= OP_GT) begin
          // Assign, not, less and greater each pair with '=' to the code six places on.
          two_v = 1'b1;
          two   = op_e'(pend_q + 4'd6);
        end
        if (two_v) begin
          pre_v  = 1'b1;
          pre    = mk_result(TOK_OPER, two, BRK_ROUND, 7'(sp_q), 8'd0, ERR_NONE);
          mode_d = MODE_NORMAL;
        end else if (pend_q == OP_DIV && b == CH_SLASH) begin
          mode_d = MODE_LINE;
        end else if (pend_q == OP_DIV && b == CH_STAR) begin
          mode_d = MODE_BLOCK;
        end else if (pend_q == OP_AND || pend_q == OP_OR) begin
          pre_v = 1'b1;
          pre   = mk_result(TOK_ERROR, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0, ERR_LONE_AMP_BAR);
          if (b == CH_NUL) begin
            clear = 1'b1;
          end else begin
            mode_d = MODE_DISCARD;
          end
        end else begin
          pre_v    = 1'b1;
          pre      = mk_result(TOK_OPER, pend_q, BRK_ROUND, 7'(sp_q), 8'd0, ERR_NONE);
          do_plain = 1'b1;
        end
      end
      MODE_LINE: begin
        if (b == CH_LF) begin
          mode_d = MODE_NORMAL;
        end else if (b == CH_NUL) begin
          do_plain = 1'b1;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (b == CH_NUL) begin
          pre_v = 1'b1;
          pre   = mk_result(TOK_ERROR, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0,
                            ERR_UNCLOSED_COMMENT);
          clear = 1'b1;
        end else if (b == CH_STAR) begin
          mode_d = MODE_BLOCK_STAR;
        end else if (b == CH_SLASH && mode_q == MODE_BLOCK_STAR) begin
          mode_d = MODE_NORMAL;
        end else begin
          mode_d = MODE_BLOCK;
        end
      end
      MODE_DISCARD: begin
        if (b == CH_NUL) begin
          clear = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      mode_d = MODE_NORMAL;
      case (cls)
        CL_WORD: begin
          mode_d = MODE_WORD;
          wc_d   = WCW'(1);
        end
        CL_OP: begin
          pend_d = op_of(b);
          mode_d = MODE_OPER;
        end
        CL_COMMA: begin
          pl_v = 1'b1;
          pl   = mk_result(TOK_COMMA, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0, ERR_NONE);
        end
        CL_SEMI: begin
          pl_v = 1'b1;
          pl   = mk_result(TOK_SEMI, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0, ERR_NONE);
        end
        CL_SPACE: begin
          mode_d = MODE_NORMAL;
        end
        CL_OPEN: begin
          pl_v = 1'b1;
          if (sp_q >= SPW'(STACK_DEPTH)) begin
            pl     = mk_result(TOK_ERROR, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0, ERR_OVERFLOW);
            mode_d = MODE_DISCARD;
          end else begin
            push = 1'b1;
            pl   = mk_result(TOK_OPEN, OP_ADD, k, 7'(sp_q + 1'b1), 8'd0, ERR_NONE);
          end
        end
        CL_CLOSE: begin
          pl_v = 1'b1;
          if (sp_q == '0 || tos_q != k) begin
            pl     = mk_result(TOK_ERROR, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0, ERR_MISMATCH);
            mode_d = MODE_DISCARD;
          end else begin
            pop = 1'b1;
            pl  = mk_result(TOK_CLOSE, OP_ADD, k, 7'(sp_q - 1'b1), 8'd0, ERR_NONE);
          end
        end
        CL_END: begin
          pl_v  = 1'b1;
          clear = 1'b1;
          if (sp_q != '0) begin
            pl = mk_result(TOK_ERROR, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0, ERR_UNCLOSED_BLOCK);
          end else begin
            pl = mk_result(TOK_END, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0, ERR_NONE);
          end
        end
        default: begin
          pl_v   = 1'b1;
          pl     = mk_result(TOK_ERROR, OP_ADD, BRK_ROUND, 7'(sp_q), 8'd0, ERR_BAD_CHAR);
          mode_d = MODE_DISCARD;
        end
      endcase
    end

    if (push) begin
      sp_d  = sp_q + 1'b1;
      tos_d = k;
    end
    if (pop) begin
      sp_d  = sp_q - 1'b1;
      tos_d = below;
    end
    if (clear) begin
      mode_d = MODE_NORMAL;
      pend_d = OP_ADD;
      wc_d   = '0;
      sp_d   = '0;
    end

    res_o.count = {1'b0, pre_v} + {1'b0, pl_v};
    if (pre_v) begin
      res_o.r0      = pre;
      res_o.r1      = pl;
      res_o.r0.last = !pl_v;
      res_o.r1.last = pl_v;
    end else begin
      res_o.r0      = pl;
      res_o.r1      = RES_IDLE;
      res_o.r0.last = pl_v;
    end
  end

  // The top entry lives in tos_q; the RAM holds the entries below it. The RAM
  // is read one below the next top, and a push forwards the old top around it.
  assign sp_rd  = (acc_i ? sp_d : sp_q) - SPW'(2);
  assign sp_wr  = sp_q - 1'b1;
  assign sp_adr = sp_rd;

  cbm_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (acc_i && push && sp_q != '0),
    .waddr_i (sp_wr[AW-1:0]),
    .wdata_i (tos_q),
    .raddr_i (sp_adr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      pend_q <= OP_ADD;
      wc_q   <= '0;
      sp_q   <= '0;
      byp_q  <= 1'b0;
    end else begin
      byp_q <= acc_i && push;
      if (acc_i) begin
        mode_q <= mode_d;
        pend_q <= pend_d;
        wc_q   <= wc_d;
        sp_q   <= sp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= tos_q;
    if (acc_i) begin
      tos_q <= tos_d;
    end
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("bracket stack pointer beyond stack depth");

  a_word_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_WORD |-> wc_q != '0)
    else $error("word mode with an empty character count");

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && mode_q == MODE_DISCARD |-> res_o.count == 2'd0)
    else $error("discard mode produced a result");

  a_push_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && push |=> sp_q == $past(sp_q) + 1'b1)
    else $error("open bracket did not deepen the stack");

endmodule

>>> rtl/char_tokenizer_bracket_matcher.sv
// Top level of the character tokenizer with bracket matching and its result queue.
//
// Input channel: one source byte per item on source_byte_i, taken when in_valid_i
// is high and in_stall_o is low. A zero byte ends the text.
// Output channel: one token per item on the result ports, taken when out_valid_o
// is high and out_stall_i is low. last_of_run_o marks the final token of a byte.
// A byte gives zero, one or two tokens. Its tokens are registered into a
// three-entry result queue, whose head drives the result ports.
// Throughput is one byte per cycle while each byte gives at most one token and the
// receiver keeps up; a byte that gives two tokens can hold back the next byte,
// since the queue stalls the input once two tokens are waiting.
// The bracket stack keeps its top in a register and the rest in a RAM addressed
// from the next stack pointer, so a bracket can be pushed or popped on every byte.
// Reset empties the queue and the stack and puts the scanner in normal mode;
// the stack RAM needs no clearing pass. When the receiver stalls, the head token
// holds and the queue fills; input stalls at two queued tokens.
module char_tokenizer_bracket_matcher import cbm_pkg::*; #(
  parameter int unsigned STACK_DEPTH  = StackDepthDefault,
  parameter int unsigned MAX_WORD_LEN = MaxWordLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] source_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [3:0] operator_code_o,
  output logic [1:0] bracket_kind_o,
  output logic [6:0] nest_depth_o,
  output logic [7:0] word_length_o,
  output logic [2:0] error_code_o,
  output logic       last_of_run_o
);

  logic       acc;
  logic       pop;
  scan_out_t  res;
  result_t    q_q [3];
  result_t    q_d [3];
  result_t    sh  [3];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic [1:0] n;

  assign in_stall_o  = cnt_q >= 2'd2;
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && !out_stall_i;

  cbm_scan #(
    .STACK_DEPTH  (STACK_DEPTH),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .source_byte_i (source_byte_i),
    .res_o         (res)
  );

  always_comb begin
    base  = cnt_q - {1'b0, pop};
    n     = acc ? res.count : 2'd0;
    sh[0] = pop ? q_q[1] : q_q[0];
    sh[1] = pop ? q_q[2] : q_q[1];
    sh[2] = q_q[2];
    for (int i = 0; i < 3; i++) begin
      q_d[i] = sh[i];
      if (n != 2'd0 && 2'(i) == base) begin
        q_d[i] = res.r0;
      end
      if (n == 2'd2 && 2'(i) == 2'(base + 2'd1)) begin
        q_d[i] = res.r1;
      end
    end
    cnt_d = base + n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign token_kind_o    = q_q[0].kind;
  assign operator_code_o = q_q[0].op;
  assign bracket_kind_o  = q_q[0].brk;
  assign nest_depth_o    = q_q[0].depth;
  assign word_length_o   = q_q[0].len;
  assign error_code_o    = q_q[0].err;
  assign last_of_run_o   = q_q[0].last;

  a_run_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> cnt_q >= 2'd2)
    else $error("first token of a pair is shown without its partner queued");

  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((token_kind_o == TOK_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not agree with token kind");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && res.count == 2'd2 && !pop |=> cnt_q == $past(cnt_q) + 2'd2)
    else $error("result queue lost a token");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bracket-matching tokenizer, driven with directed and random texts.
module testbench;
  import cbm_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomBytes   = 200;
  localparam int unsigned MaxPrinted    = 40;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] source_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [2:0] token_kind_o;
  logic [3:0] operator_code_o;
  logic [1:0] bracket_kind_o;
  logic [6:0] nest_depth_o;
  logic [7:0] word_length_o;
  logic [2:0] error_code_o;
  logic       last_of_run_o;

  char_tokenizer_bracket_matcher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .source_byte_i  (source_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .operator_code_o(operator_code_o),
    .bracket_kind_o (bracket_kind_o),
    .nest_depth_o   (nest_depth_o),
    .word_length_o  (word_length_o),
    .error_code_o   (error_code_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #1 clk_i = ~clk_i;

  // Scanner state as the testbench tracks it.
  mode_e       scan_st;
  op_e         held_op;
  int unsigned word_len;
  int unsigned open_depth;
  brk_e        open_kinds [StackDepthDefault];
  result_t     step_tokens [$];
  result_t     expected_tokens [$];

  int unsigned mismatches     = 0;
  int unsigned tokens_checked = 0;
  int unsigned bytes_scanned  = 0;
  int unsigned bytes_dropped  = 0;
  int unsigned texts_sent     = 0;
  int unsigned deepest        = 0;
  int unsigned idle_cycles    = 0;
  int unsigned stall_left     = 0;
  bit          calm           = 1'b0;

  string op_spellings [15] = '{"+", "-", "*", "/", "%", "=", "!", "<", ">",
                               "&&", "||", "==", "!=", "<=", ">="};

  function automatic class_e class_of(input logic [7:0] b);
    if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER}) return CL_WORD;
    if (b == CH_NUL) return CL_END;
    if (b inside {CH_TAB, CH_LF, CH_CR, CH_SPACE}) return CL_SPACE;
    if (b inside {CH_BANG, CH_PCT, CH_AMP, CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH,
                  CH_LT, CH_EQ, CH_GT, CH_BAR}) return CL_OP;
    if (b == CH_COMMA) return CL_COMMA;
    if (b == CH_SEMI) return CL_SEMI;
    if (b inside {CH_LPAREN, CH_LCURLY, CH_LSQ}) return CL_OPEN;
    if (b inside {CH_RPAREN, CH_RCURLY, CH_RSQ}) return CL_CLOSE;
    return CL_BAD;
  endfunction

  function automatic op_e single_op(input logic [7:0] b);
    case (b)
      CH_PLUS:  return OP_ADD;
      CH_MINUS: return OP_SUB;
      CH_STAR:  return OP_MUL;
      CH_SLASH: return OP_DIV;
      CH_PCT:   return OP_MOD;
      CH_EQ:    return OP_ASSIGN;
      CH_BANG:  return OP_NOT;
      CH_LT:    return OP_LT;
      CH_GT:    return OP_GT;
      CH_AMP:   return OP_AND;
      default:  return OP_OR;
    endcase
  endfunction

  function automatic brk_e kind_of_bracket(input logic [7:0] b);
    if (b inside {CH_LPAREN, CH_RPAREN}) return BRK_ROUND;
    if (b inside {CH_LCURLY, CH_RCURLY}) return BRK_CURLY;
    return BRK_SQUARE;
  endfunction

  function automatic logic [7:0] open_char(input brk_e k);
    case (k)
      BRK_ROUND: return CH_LPAREN;
      BRK_CURLY: return CH_LCURLY;
      default:   return CH_LSQ;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input brk_e k);
    case (k)
      BRK_ROUND: return CH_RPAREN;
      BRK_CURLY: return CH_RCURLY;
      default:   return CH_RSQ;
    endcase
  endfunction

  function automatic void push_token(input tok_e kind, input op_e op, input brk_e brk,
                                     input int unsigned len, input err_e err);
    result_t r;
    r.kind  = kind;
    r.op    = op;
    r.brk   = brk;
    r.depth = 7'(open_depth);
    r.len   = (len > 255) ? 8'd255 : 8'(len);
    r.err   = err;
    r.last  = 1'b0;
    step_tokens.insert(step_tokens.size(), r);
  endfunction

  function automatic void reset_scanner();
    scan_st    = MODE_NORMAL;
    held_op    = OP_ADD;
    word_len   = 0;
    open_depth = 0;
  endfunction

  // An error on the end byte clears everything; any other error drops bytes until the end byte.
  function automatic void raise_error(input err_e err, input logic [7:0] b);
    push_token(TOK_ERROR, OP_ADD, BRK_ROUND, 0, err);
    if (b == CH_NUL) reset_scanner();
    else scan_st = MODE_DISCARD;
  endfunction

  function automatic void scan_plain(input logic [7:0] b);
    brk_e k;
    k = kind_of_bracket(b);
    scan_st = MODE_NORMAL;
    case (class_of(b))
      CL_WORD: begin
        scan_st  = MODE_WORD;
        word_len = 1;
      end
      CL_OP: begin
        held_op = single_op(b);
        scan_st = MODE_OPER;
      end
      CL_COMMA: push_token(TOK_COMMA, OP_ADD, BRK_ROUND, 0, ERR_NONE);
      CL_SEMI:  push_token(TOK_SEMI, OP_ADD, BRK_ROUND, 0, ERR_NONE);
      CL_SPACE: ;
      CL_OPEN: begin
        if (open_depth >= StackDepthDefault) begin
          raise_error(ERR_OVERFLOW, b);
        end else begin
          open_kinds[open_depth] = k;
          open_depth++;
          if (open_depth > deepest) deepest = open_depth;
          push_token(TOK_OPEN, OP_ADD, k, 0, ERR_NONE);
        end
      end
      CL_CLOSE: begin
        if (open_depth == 0 || open_kinds[open_depth - 1] != k) begin
          raise_error(ERR_MISMATCH, b);
        end else begin
          open_depth--;
          push_token(TOK_CLOSE, OP_ADD, k, 0, ERR_NONE);
        end
      end
      CL_END: begin
        if (open_depth != 0) begin
          raise_error(ERR_UNCLOSED_BLOCK, b);
        end else begin
          push_token(TOK_END, OP_ADD, BRK_ROUND, 0, ERR_NONE);
          reset_scanner();
        end
      end
      default: raise_error(ERR_BAD_CHAR, b);
    endcase
  endfunction

  // The byte after a held operator pairs with it, opens a comment, or releases it; a lone & or | is an error.
  function automatic void scan_operator(input logic [7:0] b);
    op_e p;
    op_e pair;
    bit  paired;
    p       = held_op;
    held_op = OP_ADD;
    paired  = 1'b1;
    pair    = OP_ADD;
    if (p == OP_AND && b == CH_AMP) pair = OP_AND;
    else if (p == OP_OR && b == CH_BAR) pair = OP_OR;
    else if (p == OP_ASSIGN && b == CH_EQ) pair = OP_EQ;
    else if (p == OP_NOT && b == CH_EQ) pair = OP_NE;
    else if (p == OP_LT && b == CH_EQ) pair = OP_LE;
    else if (p == OP_GT && b == CH_EQ) pair = OP_GE;
    else paired = 1'b0;
    if (paired) begin
      push_token(TOK_OPER, pair, BRK_ROUND, 0, ERR_NONE);
      scan_st = MODE_NORMAL;
    end else if (p == OP_DIV && b == CH_SLASH) begin
      scan_st = MODE_LINE;
    end else if (p == OP_DIV && b == CH_STAR) begin
      scan_st = MODE_BLOCK;
    end else if (p == OP_AND || p == OP_OR) begin
      raise_error(ERR_LONE_AMP_BAR, b);
    end else begin
      push_token(TOK_OPER, p, BRK_ROUND, 0, ERR_NONE);
      scan_plain(b);
    end
  endfunction

  function automatic void predict_tokens(input logic [7:0] b);
    result_t tail;
    step_tokens.delete();
    if (scan_st == MODE_DISCARD) bytes_dropped++;
    else bytes_scanned++;
    case (scan_st)
      MODE_WORD: begin
        if (class_of(b) == CL_WORD) begin
          if (word_len < MaxWordLenDefault) word_len++;
        end else begin
          push_token(TOK_WORD, OP_ADD, BRK_ROUND, word_len, ERR_NONE);
          word_len = 0;
          scan_plain(b);
        end
      end
      MODE_OPER: scan_operator(b);
      MODE_LINE: begin
        if (b == CH_LF) scan_st = MODE_NORMAL;
        else if (b == CH_NUL) scan_plain(b);
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (b == CH_NUL) raise_error(ERR_UNCLOSED_COMMENT, b);
        else if (b == CH_STAR) scan_st = MODE_BLOCK_STAR;
        else if (b == CH_SLASH && scan_st == MODE_BLOCK_STAR) scan_st = MODE_NORMAL;
        else scan_st = MODE_BLOCK;
      end
      MODE_DISCARD: begin
        if (b == CH_NUL) reset_scanner();
      end
      default: scan_plain(b);
    endcase
    if (step_tokens.size() > 0) begin
      tail = step_tokens.pop_back();
      tail.last = 1'b1;
      step_tokens.insert(step_tokens.size(), tail);
    end
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] word_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 36) return 8'(8'h41 + r - 10);
    if (r < 62) return 8'(8'h61 + r - 36);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("token %0d %s: got %0h, want %0h",
                                tokens_checked, field, got, want));
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    source_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (b == CH_NUL) texts_sent++;
    predict_tokens(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Lower valid, then hold off until every predicted token has come out.
  task automatic wait_for_tokens();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall: bursts of random length, none while calm.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = calm ? 0 : pick_gap();
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("token arrived with none expected");
      end else begin
        want = expected_tokens.pop_front();
        compare_field("token_kind", 8'(token_kind_o), 8'(want.kind));
        compare_field("operator_code", 8'(operator_code_o), 8'(want.op));
        compare_field("bracket_kind", 8'(bracket_kind_o), 8'(want.brk));
        compare_field("nest_depth", 8'(nest_depth_o), 8'(want.depth));
        compare_field("word_length", word_length_o, want.len);
        compare_field("error_code", 8'(error_code_o), 8'(want.err));
        compare_field("last_of_run", 8'(last_of_run_o), 8'(want.last));
        tokens_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d tokens outstanding",
               idle_cycles, expected_tokens.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Every operator, single and paired, then comma, semicolon and the end byte.
  task automatic test_operators();
    send_text("+-*/%=!<>&&||==!=<=>=,;");
    send_byte(CH_NUL);
  endtask

  // Words of every character class, all bracket kinds, and a word cut short by the end byte.
  task automatic test_words_and_brackets();
    send_text("Az_09 ([{x}]) q");
    send_byte(CH_NUL);
  endtask

  // The star of the opening pair must not close a block comment.
  task automatic test_comments();
    send_text("//c\n/*/*/a/**/b//z");
    send_byte(CH_NUL);
    send_text("/*x*");
    send_byte(CH_NUL);
  endtask

  task automatic test_errors();
    send_text("a#b");
    send_byte(CH_NUL);
    send_text("&x");
    send_byte(CH_NUL);
    send_text("|");
    send_byte(CH_NUL);
    send_text("(]");
    send_byte(CH_NUL);
    send_text(")");
    send_byte(CH_NUL);
    send_text("(");
    send_byte(CH_NUL);
    send_byte(8'hFF);
    send_byte(CH_NUL);
  endtask

  // Fill the stack to overflow, then fill it again and unwind it completely.
  task automatic test_deep_nesting();
    brk_e kinds [$];
    brk_e k;
    for (int i = 0; i < StackDepthDefault; i++) begin
      k = brk_e'($urandom_range(0, 2));
      send_byte(open_char(k));
    end
    send_byte(open_char(BRK_CURLY));
    send_byte(CH_NUL);
    for (int i = 0; i < StackDepthDefault; i++) begin
      k = brk_e'($urandom_range(0, 2));
      kinds.insert(kinds.size(), k);
      send_byte(open_char(k));
    end
    while (kinds.size() > 0) send_byte(close_char(kinds.pop_back()));
    send_byte(CH_NUL);
  endtask

  task automatic test_long_words();
    repeat (270) send_byte(word_char());
    send_byte(CH_SEMI);
    repeat (254) send_byte(word_char());
    send_byte(CH_NUL);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(3, 30)) send_byte(8'($urandom_range(0, 255)));
    send_byte(CH_NUL);
  endtask

  // A mostly well-formed text with random content and the odd broken token.
  task automatic send_program();
    brk_e        opened [$];
    int unsigned pick;
    logic [7:0]  b;
    repeat ($urandom_range(3, 40)) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        repeat (($urandom_range(0, 49) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6))
          send_byte(word_char());
        if ($urandom_range(0, 1)) send_byte(CH_SPACE);
      end else if (pick < 45) begin
        send_text(op_spellings[$urandom_range(0, 14)]);
        if ($urandom_range(0, 1)) send_byte(CH_SPACE);
      end else if (pick < 53) begin
        send_byte(space_char());
      end else if (pick < 58) begin
        send_byte($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
      end else if (pick < 71) begin
        if (opened.size() < StackDepthDefault) begin
          opened.insert(opened.size(), brk_e'($urandom_range(0, 2)));
          send_byte(open_char(opened[$]));
        end
      end else if (pick < 84) begin
        if (opened.size() > 0) send_byte(close_char(opened.pop_back()));
      end else if (pick < 90) begin
        send_text("//");
        repeat ($urandom_range(0, 10)) begin
          b = 8'($urandom_range(1, 255));
          send_byte((b == CH_LF) ? CH_SPACE : b);
        end
        send_byte(CH_LF);
      end else if (pick < 96) begin
        send_text("/*");
        repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(1, 255)));
        send_text("*/");
      end else begin
        case ($urandom_range(0, 3))
          0: send_byte(8'($urandom_range(128, 255)));
          1: begin
            send_byte($urandom_range(0, 1) ? CH_AMP : CH_BAR);
            send_byte(word_char());
          end
          2: send_byte(close_char(brk_e'($urandom_range(0, 2))));
          default: send_byte(8'($urandom_range(1, 255)));
        endcase
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      while (opened.size() > 0) send_byte(close_char(opened.pop_back()));
    end
    send_byte(CH_NUL);
  endtask

  task automatic test_random_texts();
    int unsigned goal;
    goal = bytes_scanned + RandomBytes;
    wait_for_tokens();
    while (bytes_scanned < goal) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_program();
      if ($urandom_range(0, 7) == 0) wait_for_tokens();
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_scanner();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_operators();
    test_words_and_brackets();
    test_comments();
    test_errors();
    test_deep_nesting();
    test_long_words();
    test_random_texts();
    wait_for_tokens();
    repeat (10) @(posedge clk_i);
    $display("Scanned %0d bytes in %0d texts, %0d more dropped after errors.",
             bytes_scanned, texts_sent, bytes_dropped);
    $display("Checked %0d tokens; deepest nesting %0d, %0d field errors.",
             tokens_checked, deepest, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
